// ----- rtl/core/odr_pkg.sv -----
// ----------------------------------------------------------------------------
// odr_pkg
// Shared types and constants for the off-delay relay with button setup.
// ----------------------------------------------------------------------------
package odr_pkg;

   localparam int unsigned TICKS_PER_SEC = 4;
   localparam int unsigned SEC_PER_MIN   = 60;
   localparam int unsigned DELAY_W       = 22;
   localparam int unsigned CSR_INDEX_W   = 3;

   // Setup sequence lengths.
   localparam logic [2:0] FEEDBACK_BLINKS = 3'd5;
   localparam logic [1:0] NUM_SETTINGS    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_ON  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_OFF = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_H    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_M    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_S    = 3'd5;

   // Settings store slots.
   localparam logic [1:0] SET_SECONDS = 2'd0;
   localparam logic [1:0] SET_MINUTES = 2'd1;
   localparam logic [1:0] SET_HOURS   = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_FEEDBACK = 2'd1,
      MODE_INPUT    = 2'd2,
      MODE_SAVE     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_NONE = 2'd0,
      PH_OFF  = 2'd1,
      PH_ON   = 2'd2,
      PH_LONG = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] blink_on;
      logic [7:0] blink_off;
      logic [7:0] timeout;
      logic [7:0] boot_hours;
      logic [7:0] boot_minutes;
      logic [7:0] boot_seconds;
   } cfg_type;

   // One request: first member listed is the highest bit.
   typedef struct packed {
      logic action;
      logic button_level;
      logic signal_rise;
      logic signal_fall;
      logic press_event;
   } req_item_type;

   // One result, relay_on in bit 0.
   typedef struct packed {
      logic [7:0] save_value;
      logic [1:0] save_index;
      logic       save_valid;
      logic [1:0] mode;
      logic       led_on;
      logic       relay_on;
   } rsp_item_type;

endpackage

// ----- rtl/core/odr_csr.sv -----
// ----------------------------------------------------------------------------
// odr_csr
// Configuration register file, written through the csr channel.
// ----------------------------------------------------------------------------
module odr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [odr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_data,
   output odr_pkg::cfg_type                 cfg
);
   import odr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BLINK_ON:  cfg_in.blink_on     = csr_data;
            CSR_BLINK_OFF: cfg_in.blink_off    = csr_data;
            CSR_TIMEOUT:   cfg_in.timeout      = csr_data;
            CSR_BOOT_H:    cfg_in.boot_hours   = csr_data;
            CSR_BOOT_M:    cfg_in.boot_minutes = csr_data;
            CSR_BOOT_S:    cfg_in.boot_seconds = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_on     <= 8'd1;
         cfg_ff.blink_off    <= 8'd1;
         cfg_ff.timeout      <= 8'd12;
         cfg_ff.boot_hours   <= 8'd0;
         cfg_ff.boot_minutes <= 8'd0;
         cfg_ff.boot_seconds <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/odr_input_reg.sv -----
// ----------------------------------------------------------------------------
// odr_input_reg
// Input register stage holding one request until the core takes it.
// ----------------------------------------------------------------------------
module odr_input_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  odr_pkg::req_item_type  in_item,
   input  logic                   take,
   output logic                   out_valid,
   output odr_pkg::req_item_type  out_item
);
   import odr_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff,  item_in;

   // The stage refills in the same cycle it hands its request on.
   assign in_ready  = !valid_ff || take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            item_in = in_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ----- rtl/core/odr_ctrl.sv -----
// ----------------------------------------------------------------------------
// odr_ctrl
// Relay, delay timer and setup sequencer; advances one request per step.
// ----------------------------------------------------------------------------
module odr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  odr_pkg::req_item_type  item,
   input  odr_pkg::cfg_type       cfg,
   output odr_pkg::rsp_item_type  result
);
   import odr_pkg::*;

   localparam logic [DELAY_W-1:0] TICKS_PER_HOUR =
      DELAY_W'(SEC_PER_MIN * SEC_PER_MIN * TICKS_PER_SEC);
   localparam logic [DELAY_W-1:0] TICKS_PER_MIN  = DELAY_W'(SEC_PER_MIN * TICKS_PER_SEC);
   localparam logic [DELAY_W-1:0] TICKS_PER_S    = DELAY_W'(TICKS_PER_SEC);

   mode_type           mode_ff, mode_in;
   logic               relay_ff, relay_in;
   logic               led_ff, led_in;
   logic [7:0]         set_s_ff, set_s_in;
   logic [7:0]         set_m_ff, set_m_in;
   logic [7:0]         set_h_ff, set_h_in;
   logic [DELAY_W-1:0] delay_length_ff, delay_length_in;
   logic [DELAY_W-1:0] delay_left_ff, delay_left_in;
   logic               delay_running_ff, delay_running_in;
   logic [7:0]         phase_left_ff, phase_left_in;
   phase_type          phase_kind_ff, phase_kind_in;
   logic [2:0]         blinks_left_ff, blinks_left_in;
   logic [1:0]         settings_left_ff, settings_left_in;
   logic [7:0]         press_count_ff, press_count_in;

   logic               delay_fire;
   phase_type          fired;
   logic [1:0]         save_idx;
   logic [7:0]         blink_off_len, blink_on_len, timeout_len;

   function automatic logic [DELAY_W-1:0] delay_ticks(input logic [7:0] h,
                                                      input logic [7:0] m,
                                                      input logic [7:0] s);
      delay_ticks = DELAY_W'(h) * TICKS_PER_HOUR + DELAY_W'(m) * TICKS_PER_MIN
                  + DELAY_W'(s) * TICKS_PER_S;
   endfunction

   // A programmed length of zero runs as one tick.
   assign blink_off_len = (cfg.blink_off == 8'd0) ? 8'd1 : cfg.blink_off;
   assign blink_on_len  = (cfg.blink_on  == 8'd0) ? 8'd1 : cfg.blink_on;
   assign timeout_len   = (cfg.timeout   == 8'd0) ? 8'd1 : cfg.timeout;

   always_comb begin
      mode_in          = mode_ff;
      relay_in         = relay_ff;
      led_in           = led_ff;
      set_s_in         = set_s_ff;
      set_m_in         = set_m_ff;
      set_h_in         = set_h_ff;
      delay_length_in  = delay_length_ff;
      delay_left_in    = delay_left_ff;
      delay_running_in = delay_running_ff;
      phase_left_in    = phase_left_ff;
      phase_kind_in    = phase_kind_ff;
      blinks_left_in   = blinks_left_ff;
      settings_left_in = settings_left_ff;
      press_count_in   = press_count_ff;
      delay_fire       = 1'b0;
      fired            = PH_NONE;
      save_idx         = SET_SECONDS;
      result           = '0;

      if (step && item.action) begin
         set_h_in        = cfg.boot_hours;
         set_m_in        = cfg.boot_minutes;
         set_s_in        = cfg.boot_seconds;
         delay_length_in = delay_ticks(cfg.boot_hours, cfg.boot_minutes, cfg.boot_seconds);
         mode_in         = MODE_IDLE;
         phase_kind_in   = PH_NONE;
         phase_left_in   = 8'd0;
      end else if (step) begin
         // Both timers advance before any section looks at the events.
         if (delay_running_ff) begin
            if (delay_left_ff <= DELAY_W'(1)) begin
               delay_fire       = 1'b1;
               delay_running_in = 1'b0;
               delay_left_in    = '0;
            end else begin
               delay_left_in = delay_left_ff - DELAY_W'(1);
            end
         end
         if (phase_kind_ff != PH_NONE) begin
            phase_left_in = phase_left_ff - 8'd1;
            if (phase_left_in == 8'd0) begin
               fired         = phase_kind_ff;
               phase_kind_in = PH_NONE;
            end
         end

         if (mode_in == MODE_IDLE) begin
            if (item.press_event) begin
               mode_in          = MODE_FEEDBACK;
               relay_in         = 1'b0;
               led_in           = 1'b0;
               blinks_left_in   = FEEDBACK_BLINKS;
               settings_left_in = NUM_SETTINGS;
               phase_kind_in    = PH_OFF;
               phase_left_in    = blink_off_len;
               fired            = PH_NONE;
            end
            if (item.signal_fall) begin
               delay_running_in = 1'b0;
               delay_fire       = 1'b0;
               led_in           = 1'b1;
               relay_in         = 1'b1;
            end
            if (item.signal_rise) begin
               delay_left_in    = delay_length_ff;
               delay_running_in = 1'b1;
               delay_fire       = 1'b0;
            end
            if (delay_fire) begin
               led_in   = 1'b0;
               relay_in = 1'b0;
            end
         end

         if (mode_in == MODE_FEEDBACK) begin
            if (fired == PH_ON) begin
               led_in = 1'b0;
               if (blinks_left_in != 3'd0) begin
                  blinks_left_in = blinks_left_in - 3'd1;
               end
               fired = PH_NONE;
               if (blinks_left_in == 3'd0) begin
                  if (settings_left_in == 2'd0) begin
                     mode_in = MODE_IDLE;
                  end else begin
                     mode_in        = MODE_INPUT;
                     press_count_in = 8'd0;
                     phase_kind_in  = PH_LONG;
                     phase_left_in  = timeout_len;
                  end
               end else begin
                  phase_kind_in = PH_OFF;
                  phase_left_in = blink_off_len;
               end
            end
            if (fired == PH_OFF) begin
               led_in        = 1'b1;
               phase_kind_in = PH_ON;
               phase_left_in = blink_on_len;
               fired         = PH_NONE;
            end
         end

         if (mode_in == MODE_INPUT) begin
            led_in = !item.button_level;
            if (item.press_event) begin
               phase_kind_in  = PH_LONG;
               phase_left_in  = timeout_len;
               fired          = PH_NONE;
               press_count_in = press_count_in + 8'd1;
            end
            if (fired == PH_LONG) begin
               mode_in = MODE_SAVE;
            end
         end

         if (mode_in == MODE_SAVE) begin
            mode_in        = MODE_FEEDBACK;
            blinks_left_in = FEEDBACK_BLINKS;
            phase_kind_in  = PH_OFF;
            phase_left_in  = blink_off_len;
            if (settings_left_in != 2'd0) begin
               settings_left_in = settings_left_in - 2'd1;
            end
            save_idx = (settings_left_in == SET_HOURS || settings_left_in == SET_MINUTES)
                     ? settings_left_in : SET_SECONDS;
            case (save_idx)
               SET_HOURS:   set_h_in = press_count_in;
               SET_MINUTES: set_m_in = press_count_in;
               default:     set_s_in = press_count_in;
            endcase
            result.save_valid = 1'b1;
            result.save_index = save_idx;
            result.save_value = press_count_in;
            if (settings_left_in == 2'd0) begin
               delay_length_in = delay_ticks(set_h_in, set_m_in, set_s_in);
            end
         end
      end

      result.relay_on = relay_in;
      result.led_on   = led_in;
      result.mode     = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         relay_ff         <= 1'b0;
         led_ff           <= 1'b0;
         set_s_ff         <= 8'd0;
         set_m_ff         <= 8'd0;
         set_h_ff         <= 8'd0;
         delay_length_ff  <= '0;
         delay_left_ff    <= '0;
         delay_running_ff <= 1'b0;
         phase_left_ff    <= 8'd0;
         phase_kind_ff    <= PH_NONE;
         blinks_left_ff   <= 3'd0;
         settings_left_ff <= 2'd0;
         press_count_ff   <= 8'd0;
      end else begin
         mode_ff          <= mode_in;
         relay_ff         <= relay_in;
         led_ff           <= led_in;
         set_s_ff         <= set_s_in;
         set_m_ff         <= set_m_in;
         set_h_ff         <= set_h_in;
         delay_length_ff  <= delay_length_in;
         delay_left_ff    <= delay_left_in;
         delay_running_ff <= delay_running_in;
         phase_left_ff    <= phase_left_in;
         phase_kind_ff    <= phase_kind_in;
         blinks_left_ff   <= blinks_left_in;
         settings_left_ff <= settings_left_in;
         press_count_ff   <= press_count_in;
      end
   end

endmodule

// ----- rtl/core/odr_output_reg.sv -----
// ----------------------------------------------------------------------------
// odr_output_reg
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module odr_output_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  odr_pkg::rsp_item_type  in_item,
   output logic                   free,
   output logic                   out_valid,
   input  logic                   out_ready,
   output odr_pkg::rsp_item_type  out_item
);
   import odr_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff,  item_in;

   // Free when empty or when the held result leaves this cycle.
   assign free      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ----- rtl/core/off_delay_relay_with_button_setup.sv -----
// ----------------------------------------------------------------------------
// off_delay_relay_with_button_setup
// Off-delay timer relay with single-button programming of hours, minutes and
// seconds; one request is one 250 ms tick or a load of the boot settings.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                        Contents
//  req      in         req_tvalid/tready/tdata/user one tick or load request
//  rsp      out        rsp_tvalid/tready/tdata      one result per request
//  csr      in         csr_valid/ready/index/data   8-bit configuration writes
//
//  A request passes through the input register, the control step and the
//  result register, and one request is taken every cycle while the result
//  side keeps up.
//  Reset clears all control state and loads the register defaults.
//  A stalled result register holds the input register, which then holds req.
// ----------------------------------------------------------------------------
module off_delay_relay_with_button_setup (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] press_event, [1] signal_fall, [2] signal_rise, [3] button_level
   input  logic [7:0]                       req_tdata,
   // [0] action
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] relay_on, [1] led_on, [3:2] mode, [4] save_valid, [6:5] save_index,
   // [14:7] save_value
   output logic [15:0]                      rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [odr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_data
);
   import odr_pkg::*;

   cfg_type      cfg;
   req_item_type req_item, stage_item;
   rsp_item_type step_result, rsp_item;
   logic         stage_valid, out_free, step;

   assign req_item.action       = req_tuser;
   assign req_item.press_event  = req_tdata[0];
   assign req_item.signal_fall  = req_tdata[1];
   assign req_item.signal_rise  = req_tdata[2];
   assign req_item.button_level = req_tdata[3];

   assign step      = stage_valid && out_free;
   assign rsp_tdata = {1'b0, rsp_item};

   odr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   odr_input_reg u_input_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .take      (step),
      .out_valid (stage_valid),
      .out_item  (stage_item)
   );

   odr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (stage_item),
      .cfg    (cfg),
      .result (step_result)
   );

   odr_output_reg u_output_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .in_item   (step_result),
      .free      (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

endmodule
